// ===== design/xnor_popcount_binary_conv_assert.svh =====
// Assertion macros shared by the binary convolution block.
`ifndef XNOR_POPCOUNT_BINARY_CONV_ASSERT_SVH
`define XNOR_POPCOUNT_BINARY_CONV_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define XPBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xpbc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define XPBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xpbc: next-cycle check failed");

`endif

// ===== design/xpbc_pkg.sv =====
package xpbc_pkg;

    // Fixed widths of the ports
    localparam int ADDR_W    = 10;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int CH_W      = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;

    // Lane arithmetic: bits consumed per shift step and sum width
    localparam int DIGIT   = 8;
    localparam int SUM_W   = 11;
    localparam int SUM_MAX = 2047;

    typedef enum logic [1:0] {
        FUNC_LOAD_ACT = 2'd0,
        FUNC_LOAD_WGT = 2'd1,
        FUNC_COMPUTE  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT = 3'd0,
        CFG_IN_WIDTH  = 3'd1,
        CFG_KERNEL_H  = 3'd2,
        CFG_KERNEL_W  = 3'd3,
        CFG_STRIDE_H  = 3'd4,
        CFG_STRIDE_W  = 3'd5,
        CFG_PAD_H     = 3'd6,
        CFG_PAD_W     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WLOAD,
        ST_SCAN,
        ST_LOAD,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Controls from the sequencer to every channel lane
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } lane_ctl_t;

endpackage

// ===== design/xnor_popcount_binary_conv.sv =====
// Activation load: written when taken, busy stays low. Weight load: busy while the word
// is written in ST_WLOAD. Compute: busy until the last sum; a tap inside the image is
// read in ST_SCAN, loaded in ST_LOAD and consumed one 8-bit digit per step in ST_SHIFT,
// a tap outside is skipped in ST_SCAN. The rate is set by the 8-bit digit step of the
// channel lanes and the single activation read port; all channels accumulate in
// parallel, results stream out one per cycle with no stall. Reset restores the default
// geometry and idles the sequencer; store contents are undefined until written.
`include "xnor_popcount_binary_conv_assert.svh"

module xnor_popcount_binary_conv #(
    parameter int IN_WORDS     = 4,
    parameter int OUT_CHANNELS = 16,
    parameter int MAX_IN_ROWS  = 16,
    parameter int MAX_IN_COLS  = 16,
    parameter int MAX_KERNEL   = 3,
    parameter int WORD_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [xpbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xpbc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic [xpbc_pkg::ADDR_W-1:0]       addr,
    input  logic [xpbc_pkg::DATA_W-1:0]       data,
    input  logic [xpbc_pkg::POS_W-1:0]        out_row,
    input  logic [xpbc_pkg::POS_W-1:0]        out_col,
    output logic                              valid,
    output logic [xpbc_pkg::CH_W-1:0]         channel,
    output logic [xpbc_pkg::SUM_W-1:0]        sum,
    output logic                              last
);

    localparam int PLANE      = MAX_IN_ROWS * MAX_IN_COLS;
    localparam int ACT_DEPTH  = IN_WORDS * PLANE;
    localparam int BANK_DEPTH = IN_WORDS * MAX_KERNEL * MAX_KERNEL;
    localparam int WGT_DEPTH  = OUT_CHANNELS * BANK_DEPTH;
    localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CW         = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int WW         = (IN_WORDS > 1) ? $clog2(IN_WORDS) : 1;
    localparam int NDIG       = (WORD_BITS + xpbc_pkg::DIGIT - 1) / xpbc_pkg::DIGIT;
    localparam int DW         = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int RECIP      = (1 << xpbc_pkg::ADDR_W) / BANK_DEPTH;
    localparam int BASE_W     = 10;

    // Configuration registers
    logic [4:0] in_height_reg, in_width_reg;
    logic [1:0] kernel_h_reg, kernel_w_reg;
    logic [2:0] stride_h_reg, stride_w_reg;
    logic [1:0] pad_h_reg, pad_w_reg;

    // Sequencer
    xpbc_pkg::state_t   state_reg, state_next;
    logic [WW-1:0]      wcnt_reg, wcnt_next;
    logic [1:0]         kh_reg, kh_next, kw_reg, kw_next;
    logic [DW-1:0]      dig_reg, dig_next;
    logic [CW-1:0]      ch_reg, ch_next;
    logic [WW-1:0]      wcnt_adv;
    logic [1:0]         kh_adv, kw_adv;

    // Item payload
    logic [xpbc_pkg::ADDR_W-1:0]  addr_reg;
    logic [WORD_BITS-1:0]         wdata_reg;
    logic [CW-1:0]                q_reg;
    logic signed [BASE_W-1:0]     row_base_reg, col_base_reg;

    // Tap geometry
    logic [4:0]                   ih_n, iw_n;
    logic [1:0]                   kh_n, kw_n;
    logic signed [BASE_W-1:0]     r_s, c_s;
    logic [BASE_W-1:0]            r_u, c_u;
    logic                         tap_ok, last_tap, no_taps, accept;

    // Store ports
    logic                         act_we, rd_en, wgt_we;
    logic [ACT_AW-1:0]            act_raddr;
    logic [BANK_AW-1:0]           wgt_roff, wgt_woff;
    logic [CW-1:0]                wgt_wch;
    logic [xpbc_pkg::ADDR_W-1:0]  rem;
    logic                         rem_fix;
    logic [WORD_BITS-1:0]         act_rdata;
    logic [OUT_CHANNELS-1:0][WORD_BITS-1:0] wgt_rdata;

    xpbc_pkg::lane_ctl_t          lane_ctl;
    logic [xpbc_pkg::SUM_W-1:0]   acc [OUT_CHANNELS];

    assign accept = start && !busy;
    assign busy   = (state_reg != xpbc_pkg::ST_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg <= 5'd16;
            in_width_reg  <= 5'd16;
            kernel_h_reg  <= 2'd3;
            kernel_w_reg  <= 2'd3;
            stride_h_reg  <= 3'd1;
            stride_w_reg  <= 3'd1;
            pad_h_reg     <= 2'd1;
            pad_w_reg     <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (xpbc_pkg::cfg_idx_t'(cfg_index))
                xpbc_pkg::CFG_IN_HEIGHT: in_height_reg <= cfg_data[4:0];
                xpbc_pkg::CFG_IN_WIDTH:  in_width_reg  <= cfg_data[4:0];
                xpbc_pkg::CFG_KERNEL_H:  kernel_h_reg  <= cfg_data[1:0];
                xpbc_pkg::CFG_KERNEL_W:  kernel_w_reg  <= cfg_data[1:0];
                xpbc_pkg::CFG_STRIDE_H:  stride_h_reg  <= cfg_data[2:0];
                xpbc_pkg::CFG_STRIDE_W:  stride_w_reg  <= cfg_data[2:0];
                xpbc_pkg::CFG_PAD_H:     pad_h_reg     <= cfg_data[1:0];
                xpbc_pkg::CFG_PAD_W:     pad_w_reg     <= cfg_data[1:0];
            endcase
        end
    end

    // Saturate extents to the store geometry
    assign ih_n = (32'(in_height_reg) > MAX_IN_ROWS) ? 5'(MAX_IN_ROWS) : in_height_reg;
    assign iw_n = (32'(in_width_reg) > MAX_IN_COLS) ? 5'(MAX_IN_COLS) : in_width_reg;
    assign kh_n = (32'(kernel_h_reg) > MAX_KERNEL) ? 2'(MAX_KERNEL) : kernel_h_reg;
    assign kw_n = (32'(kernel_w_reg) > MAX_KERNEL) ? 2'(MAX_KERNEL) : kernel_w_reg;

    // Image position of the current tap and its bounds check
    assign r_s     = row_base_reg + $signed({8'b0, kh_reg});
    assign c_s     = col_base_reg + $signed({8'b0, kw_reg});
    assign r_u     = r_s;
    assign c_u     = c_s;
    assign tap_ok  = !r_s[BASE_W-1] && (r_u < BASE_W'(ih_n))
                  && !c_s[BASE_W-1] && (c_u < BASE_W'(iw_n));
    assign no_taps = (kh_n == 2'd0) || (kw_n == 2'd0);
    assign last_tap = (wcnt_reg == WW'(IN_WORDS - 1)) && (kh_reg == kh_n - 2'd1)
                   && (kw_reg == kw_n - 2'd1);

    // Tap walk: kw fastest, then kh, then input word
    always_comb
    begin
        wcnt_adv = wcnt_reg;
        kh_adv   = kh_reg;
        kw_adv   = kw_reg + 2'd1;
        if (kw_reg == kw_n - 2'd1)
        begin
            kw_adv = 2'd0;
            kh_adv = kh_reg + 2'd1;
            if (kh_reg == kh_n - 2'd1)
            begin
                kh_adv   = 2'd0;
                wcnt_adv = wcnt_reg + WW'(1);
            end
        end
    end

    // Store addresses for the current tap
    assign act_raddr = ACT_AW'(32'(wcnt_reg) * PLANE + 32'(r_u) * MAX_IN_COLS + 32'(c_u));
    assign wgt_roff  = BANK_AW'((32'(wcnt_reg) * MAX_KERNEL + 32'(kh_reg)) * MAX_KERNEL
                                + 32'(kw_reg));

    // Weight load: finish the reciprocal split of the address into bank and offset
    assign rem      = addr_reg - xpbc_pkg::ADDR_W'(32'(q_reg) * BANK_DEPTH);
    assign rem_fix  = (32'(rem) >= BANK_DEPTH);
    assign wgt_wch  = rem_fix ? (q_reg + CW'(1)) : q_reg;
    assign wgt_woff = rem_fix ? BANK_AW'(32'(rem) - BANK_DEPTH) : BANK_AW'(rem);

    assign act_we = accept && (func == xpbc_pkg::FUNC_LOAD_ACT) && (32'(addr) < ACT_DEPTH);

    // Next state and lane controls
    always_comb
    begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        kh_next    = kh_reg;
        kw_next    = kw_reg;
        dig_next   = dig_reg;
        ch_next    = ch_reg;
        rd_en      = 1'b0;
        wgt_we     = 1'b0;
        lane_ctl   = '0;
        unique case (state_reg)
            xpbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (xpbc_pkg::func_t'(func))
                        xpbc_pkg::FUNC_LOAD_WGT:
                        begin
                            if (32'(addr) < WGT_DEPTH)
                            begin
                                state_next = xpbc_pkg::ST_WLOAD;
                            end
                        end
                        xpbc_pkg::FUNC_COMPUTE:
                        begin
                            lane_ctl.clear = 1'b1;
                            wcnt_next      = '0;
                            kh_next        = 2'd0;
                            kw_next        = 2'd0;
                            ch_next        = '0;
                            state_next     = xpbc_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = xpbc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            xpbc_pkg::ST_WLOAD:
            begin
                wgt_we     = 1'b1;
                state_next = xpbc_pkg::ST_IDLE;
            end
            xpbc_pkg::ST_SCAN:
            begin
                if (no_taps)
                begin
                    state_next = xpbc_pkg::ST_EMIT;
                end
                else if (tap_ok)
                begin
                    rd_en      = 1'b1;
                    state_next = xpbc_pkg::ST_LOAD;
                end
                else
                begin
                    wcnt_next = wcnt_adv;
                    kh_next   = kh_adv;
                    kw_next   = kw_adv;
                    if (last_tap)
                    begin
                        state_next = xpbc_pkg::ST_EMIT;
                    end
                end
            end
            xpbc_pkg::ST_LOAD:
            begin
                lane_ctl.load = 1'b1;
                dig_next      = '0;
                state_next    = xpbc_pkg::ST_SHIFT;
            end
            xpbc_pkg::ST_SHIFT:
            begin
                lane_ctl.shift = 1'b1;
                dig_next       = dig_reg + DW'(1);
                if (dig_reg == DW'(NDIG - 1))
                begin
                    wcnt_next = wcnt_adv;
                    kh_next   = kh_adv;
                    kw_next   = kw_adv;
                    if (last_tap)
                    begin
                        state_next = xpbc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = xpbc_pkg::ST_SCAN;
                    end
                end
            end
            xpbc_pkg::ST_EMIT:
            begin
                ch_next = ch_reg + CW'(1);
                if (ch_reg == CW'(OUT_CHANNELS - 1))
                begin
                    state_next = xpbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xpbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xpbc_pkg::ST_IDLE;
            wcnt_reg  <= '0;
            kh_reg    <= 2'd0;
            kw_reg    <= 2'd0;
            dig_reg   <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            kh_reg    <= kh_next;
            kw_reg    <= kw_next;
            dig_reg   <= dig_next;
            ch_reg    <= ch_next;
        end
    end

    // Hold the payload of each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg     <= addr;
            wdata_reg    <= WORD_BITS'(data);
            q_reg        <= CW'((32'(addr) * RECIP) >> xpbc_pkg::ADDR_W);
            row_base_reg <= $signed(BASE_W'(out_row) * BASE_W'(stride_h_reg))
                          - $signed(BASE_W'(pad_h_reg));
            col_base_reg <= $signed(BASE_W'(out_col) * BASE_W'(stride_w_reg))
                          - $signed(BASE_W'(pad_w_reg));
        end
    end

    xpbc_act_mem #(
        .DEPTH (ACT_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_act_mem (
        .clk   (clk),
        .we    (act_we),
        .waddr (ACT_AW'(addr)),
        .wdata (WORD_BITS'(data)),
        .re    (rd_en),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    xpbc_wgt_store #(
        .OUT_CHANNELS (OUT_CHANNELS),
        .BANK_DEPTH   (BANK_DEPTH),
        .WIDTH        (WORD_BITS)
    ) u_wgt_store (
        .clk   (clk),
        .we    (wgt_we),
        .wch   (wgt_wch),
        .woff  (wgt_woff),
        .wdata (wdata_reg),
        .re    (rd_en),
        .roff  (wgt_roff),
        .rdata (wgt_rdata)
    );

    for (genvar g = 0; g < OUT_CHANNELS; g++)
    begin : g_lane
        xpbc_lane #(
            .WORD_BITS (WORD_BITS)
        ) u_lane (
            .clk      (clk),
            .ctl      (lane_ctl),
            .act_word (act_rdata),
            .wgt_word (wgt_rdata[g]),
            .acc      (acc[g])
        );
    end

    // Stream one channel sum per cycle
    assign valid   = (state_reg == xpbc_pkg::ST_EMIT);
    assign channel = xpbc_pkg::CH_W'(ch_reg);
    assign sum     = acc[ch_reg];
    assign last    = valid && (ch_reg == CW'(OUT_CHANNELS - 1));

    `XPBC_ASSERT_NEXT(a_channel_order, valid && !last, valid && (channel == xpbc_pkg::CH_W'($past(channel) + 1'b1)))
    `XPBC_ASSERT_NEXT(a_last_ends_item, valid && last, !valid && !busy)
    `XPBC_ASSERT_NEXT(a_compute_busy, start && !busy && (func == xpbc_pkg::FUNC_COMPUTE), busy)
    `XPBC_ASSERT_NOW(a_valid_busy, valid, busy)

endmodule

// ===== design/xpbc_act_mem.sv =====
module xpbc_act_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one activation word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/xpbc_wgt_store.sv =====
module xpbc_wgt_store #(
    parameter int OUT_CHANNELS = 16,
    parameter int BANK_DEPTH   = 36,
    parameter int WIDTH        = 32,
    localparam int CW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1,
    localparam int BW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [CW-1:0]                        wch,
    input  logic [BW-1:0]                        woff,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [BW-1:0]                        roff,
    output logic [OUT_CHANNELS-1:0][WIDTH-1:0]   rdata
);

    logic [WIDTH-1:0] rdata_reg [OUT_CHANNELS];

    // One bank per output channel, all read at the same offset
    for (genvar g = 0; g < OUT_CHANNELS; g++)
    begin : g_bank
        logic [WIDTH-1:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (we && (wch == CW'(g)))
            begin
                bank_mem[woff] <= wdata;
            end
        end

        always_ff @(posedge clk)
        begin
            if (re)
            begin
                rdata_reg[g] <= bank_mem[roff];
            end
        end
    end

    // Pack the bank outputs
    always_comb
    begin
        for (int i = 0; i < OUT_CHANNELS; i++)
        begin
            rdata[i] = rdata_reg[i];
        end
    end

endmodule

// ===== design/xpbc_lane.sv =====
module xpbc_lane #(
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  xpbc_pkg::lane_ctl_t         ctl,
    input  logic [WORD_BITS-1:0]        act_word,
    input  logic [WORD_BITS-1:0]        wgt_word,
    output logic [xpbc_pkg::SUM_W-1:0]  acc
);

    localparam int NDIG = (WORD_BITS + xpbc_pkg::DIGIT - 1) / xpbc_pkg::DIGIT;
    localparam int SHW  = NDIG * xpbc_pkg::DIGIT;
    localparam int PC_W = $clog2(xpbc_pkg::DIGIT + 1);

    logic [SHW-1:0]                bits_reg, bits_next;
    logic [xpbc_pkg::SUM_W-1:0]    acc_reg, acc_next;
    logic [WORD_BITS-1:0]          xnor_word;
    logic [PC_W-1:0]               digit_count;
    logic [xpbc_pkg::SUM_W:0]      sum_wide;

    function automatic logic [PC_W-1:0] digit_ones(input logic [xpbc_pkg::DIGIT-1:0] d);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < xpbc_pkg::DIGIT; i++)
        begin
            n = n + PC_W'(d[i]);
        end
        return n;
    endfunction

    assign xnor_word   = ~(act_word ^ wgt_word);
    assign digit_count = digit_ones(bits_reg[xpbc_pkg::DIGIT-1:0]);
    assign sum_wide    = {1'b0, acc_reg} + (xpbc_pkg::SUM_W + 1)'(digit_count);

    // Clear the sum, load matching bits, then consume one digit per cycle while shift is high into the saturating sum
    always_comb
    begin
        bits_next = bits_reg;
        acc_next  = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        if (ctl.load)
        begin
            bits_next = SHW'(xnor_word);
        end
        if (ctl.shift)
        begin
            bits_next = bits_reg >> xpbc_pkg::DIGIT;
            if (32'(sum_wide) > xpbc_pkg::SUM_MAX)
            begin
                acc_next = xpbc_pkg::SUM_W'(xpbc_pkg::SUM_MAX);
            end
            else
            begin
                acc_next = sum_wide[xpbc_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import xpbc_pkg::*;

    localparam int IN_WORDS  = 4;
    localparam int OUT_CH    = 16;
    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int MAX_K     = 3;
    localparam int ACT_DEPTH = IN_WORDS * MAX_ROWS * MAX_COLS;
    localparam int WGT_DEPTH = OUT_CH * IN_WORDS * MAX_K * MAX_K;
    localparam int TAIL_CYCLES = 250;
    localparam int SETTLE_CYCLES = 8;

    // Code outside the defined operations: the block must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  orow;
        logic [POS_W-1:0]  ocol;
        int unsigned       gap;
    } conv_cmd_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SUM_W-1:0] sum;
        logic             last;
    } chan_sum_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           func = FUNC_LOAD_ACT;
    logic [ADDR_W-1:0]    addr = '0;
    logic [DATA_W-1:0]    data = '0;
    logic [POS_W-1:0]     out_row = '0;
    logic [POS_W-1:0]     out_col = '0;
    logic                 valid;
    logic [CH_W-1:0]      channel;
    logic [SUM_W-1:0]     sum;
    logic                 last;

    // Mirror of the block: stores and geometry registers
    logic [DATA_W-1:0] act_mem [ACT_DEPTH];
    logic [DATA_W-1:0] wgt_mem [WGT_DEPTH];
    logic [CFG_W-1:0]  geo [8];

    conv_cmd_t cmd_q [$];
    chan_sum_t sum_exp_q [$];

    conv_cmd_t   cur_cmd;
    conv_cmd_t   stage_cmd;
    conv_cmd_t   next_cmd;
    logic        staged = 1'b0;
    int unsigned gap_cnt = 0;
    chan_sum_t   exp_sum;

    int err_cnt = 0;
    int n_xfer = 0;
    int n_compute = 0;
    int n_results = 0;
    int n_cfg = 0;
    int n_settings = 0;

    xnor_popcount_binary_conv u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .addr      (addr),
        .data      (data),
        .out_row   (out_row),
        .out_col   (out_col),
        .valid     (valid),
        .channel   (channel),
        .sum       (sum),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sum the XNOR matches of every channel for one output position
    function automatic void predict_channel_sums(input logic [POS_W-1:0] orow,
                                                 input logic [POS_W-1:0] ocol);
        int ih_n;
        int iw_n;
        int kh_n;
        int kw_n;
        int r;
        int c;
        int total;
        chan_sum_t e;
        ih_n = (geo[CFG_IN_HEIGHT] > MAX_ROWS) ? MAX_ROWS : int'(geo[CFG_IN_HEIGHT]);
        iw_n = (geo[CFG_IN_WIDTH] > MAX_COLS) ? MAX_COLS : int'(geo[CFG_IN_WIDTH]);
        kh_n = (geo[CFG_KERNEL_H] > MAX_K) ? MAX_K : int'(geo[CFG_KERNEL_H]);
        kw_n = (geo[CFG_KERNEL_W] > MAX_K) ? MAX_K : int'(geo[CFG_KERNEL_W]);
        for (int ch = 0; ch < OUT_CH; ch++)
        begin
            total = 0;
            for (int w = 0; w < IN_WORDS; w++)
            begin
                for (int kh = 0; kh < kh_n; kh++)
                begin
                    r = int'(orow) * int'(geo[CFG_STRIDE_H]) - int'(geo[CFG_PAD_H]) + kh;
                    if (r < 0 || r >= ih_n)
                        continue;
                    for (int kw = 0; kw < kw_n; kw++)
                    begin
                        c = int'(ocol) * int'(geo[CFG_STRIDE_W]) - int'(geo[CFG_PAD_W]) + kw;
                        if (c < 0 || c >= iw_n)
                            continue;
                        total += $countones(~(act_mem[(w * MAX_ROWS + r) * MAX_COLS + c]
                            ^ wgt_mem[((ch * IN_WORDS + w) * MAX_K + kh) * MAX_K + kw]));
                    end
                end
            end
            if (total > SUM_MAX)
                total = SUM_MAX;
            e.channel = CH_W'(ch);
            e.sum = SUM_W'(total);
            e.last = (ch == OUT_CH - 1);
            sum_exp_q.push_back(e);
        end
    endfunction

    // Mirror a completed transfer: write a store or predict the channel sums
    function automatic void commit_cmd(input conv_cmd_t c);
        case (c.func)
            FUNC_LOAD_ACT:
                act_mem[c.addr] = c.data;
            FUNC_LOAD_WGT:
                if (c.addr < WGT_DEPTH)
                    wgt_mem[c.addr] = c.data;
            FUNC_COMPUTE:
            begin
                n_compute++;
                predict_channel_sums(c.orow, c.ocol);
            end
            default: ;
        endcase
    endfunction

    task automatic drive_cmd(input conv_cmd_t c);
        cur_cmd = c;
        start   <= 1'b1;
        func    <= c.func;
        addr    <= c.addr;
        data    <= c.data;
        out_row <= c.orow;
        out_col <= c.ocol;
    endtask

    // Command driver: hold while busy, insert the drawn gap before each command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            func    <= FUNC_LOAD_ACT;
            addr    <= '0;
            data    <= '0;
            out_row <= '0;
            out_col <= '0;
            staged  = 1'b0;
            gap_cnt = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                n_xfer++;
                commit_cmd(cur_cmd);
            end
            if (start && busy)
            begin
                // hold the command until the block takes it
            end
            else if (gap_cnt != 0)
            begin
                start <= 1'b0;
                gap_cnt--;
            end
            else if (staged)
            begin
                drive_cmd(stage_cmd);
                staged = 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                next_cmd = cmd_q.pop_front();
                if (next_cmd.gap == 0)
                    drive_cmd(next_cmd);
                else
                begin
                    stage_cmd = next_cmd;
                    staged    = 1'b1;
                    gap_cnt   = next_cmd.gap - 1;
                    start     <= 1'b0;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor: compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            n_results++;
            if (sum_exp_q.size() == 0)
            begin
                $error("unexpected result: channel %0d sum %0d last %0b", channel, sum, last);
                err_cnt++;
            end
            else
            begin
                exp_sum = sum_exp_q.pop_front();
                if (channel !== exp_sum.channel)
                begin
                    $error("channel: expected %0d, actual %0d", exp_sum.channel, channel);
                    err_cnt++;
                end
                if (sum !== exp_sum.sum)
                begin
                    $error("sum: expected %0d, actual %0d", exp_sum.sum, sum);
                    err_cnt++;
                end
                if (last !== exp_sum.last)
                begin
                    $error("last: expected %0b, actual %0b", exp_sum.last, last);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void push_cmd(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                                     input logic [DATA_W-1:0] d, input logic [POS_W-1:0] r,
                                     input logic [POS_W-1:0] c, input int unsigned g);
        conv_cmd_t cmd;
        cmd.func = f;
        cmd.addr = a;
        cmd.data = d;
        cmd.orow = r;
        cmd.ocol = c;
        cmd.gap  = g;
        cmd_q.push_back(cmd);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    // Mostly positions whose window overlaps the image, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_pos(input int extent, input int k,
                                                  input int s, input int p);
        int span;
        if (s == 0)
            span = 32;
        else
            span = (extent + 2 * p - k) / s + 1;
        if (span < 1)
            span = 1;
        if (span > 32)
            span = 32;
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, span - 1));
    endfunction

    // Draw one command; returns 0 for the unused function code, which the block ignores
    function automatic bit push_random(input int unsigned gap_max);
        int unsigned pick;
        int unsigned g;
        int ih_n;
        int iw_n;
        int row;
        int col;
        pick = $urandom_range(0, 99);
        g = $urandom_range(0, gap_max);
        ih_n = (geo[CFG_IN_HEIGHT] > MAX_ROWS) ? MAX_ROWS : int'(geo[CFG_IN_HEIGHT]);
        iw_n = (geo[CFG_IN_WIDTH] > MAX_COLS) ? MAX_COLS : int'(geo[CFG_IN_WIDTH]);
        if (pick < 40)
        begin
            push_cmd(FUNC_COMPUTE, ADDR_W'($urandom), $urandom,
                     pick_pos(ih_n, int'(geo[CFG_KERNEL_H]), int'(geo[CFG_STRIDE_H]),
                              int'(geo[CFG_PAD_H])),
                     pick_pos(iw_n, int'(geo[CFG_KERNEL_W]), int'(geo[CFG_STRIDE_W]),
                              int'(geo[CFG_PAD_W])), g);
        end
        else if (pick < 65)
        begin
            // favor rows and columns that the current geometry reads
            row = (ih_n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, ih_n - 1)
                                                           : $urandom_range(0, 15);
            col = (iw_n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, iw_n - 1)
                                                           : $urandom_range(0, 15);
            push_cmd(FUNC_LOAD_ACT,
                     ADDR_W'(($urandom_range(0, IN_WORDS - 1) * MAX_ROWS + row) * MAX_COLS
                             + col),
                     rand_word(), POS_W'($urandom), POS_W'($urandom), g);
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 6) == 0)
                push_cmd(FUNC_LOAD_WGT, ADDR_W'($urandom_range(WGT_DEPTH, 1023)), rand_word(),
                         POS_W'($urandom), POS_W'($urandom), g);
            else
                push_cmd(FUNC_LOAD_WGT, ADDR_W'($urandom_range(0, WGT_DEPTH - 1)), rand_word(),
                         POS_W'($urandom), POS_W'($urandom), g);
        end
        else
        begin
            push_cmd(FUNC_UNUSED, ADDR_W'($urandom), $urandom, POS_W'($urandom),
                     POS_W'($urandom), g);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly legal register values, sometimes any 5-bit value
    function automatic logic [CFG_W-1:0] rand_geo(input cfg_idx_t idx);
        if ($urandom_range(0, 3) == 0)
            return CFG_W'($urandom_range(0, 31));
        case (idx)
            CFG_IN_HEIGHT, CFG_IN_WIDTH: return CFG_W'($urandom_range(1, 16));
            CFG_KERNEL_H, CFG_KERNEL_W:  return CFG_W'($urandom_range(1, 3));
            CFG_STRIDE_H, CFG_STRIDE_W:  return CFG_W'($urandom_range(1, 4));
            default:                     return CFG_W'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || staged || gap_cnt != 0 || start
               || sum_exp_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_cfg++;
        // keep only the bits each register holds
        case (idx)
            CFG_KERNEL_H, CFG_KERNEL_W, CFG_PAD_H, CFG_PAD_W: geo[idx] = val & 5'h03;
            CFG_STRIDE_H, CFG_STRIDE_W:                       geo[idx] = val & 5'h07;
            default:                                          geo[idx] = val;
        endcase
    endtask

    // Drain, settle, reprogram the geometry, then queue a batch of commands
    task automatic run_phase(input logic [0:7][CFG_W-1:0] raw, input int n_items,
                             input int unsigned gap_max);
        int counted;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
            write_reg(cfg_idx_t'(i), raw[i]);
        n_settings++;
        @(negedge clk);
        counted = 0;
        while (counted < n_items)
            if (push_random(gap_max))
                counted++;
    endtask

    initial
    begin
        logic [0:7][CFG_W-1:0] raw;
        geo[CFG_IN_HEIGHT] = 5'd16;
        geo[CFG_IN_WIDTH]  = 5'd16;
        geo[CFG_KERNEL_H]  = 5'd3;
        geo[CFG_KERNEL_W]  = 5'd3;
        geo[CFG_STRIDE_H]  = 5'd1;
        geo[CFG_STRIDE_W]  = 5'd1;
        geo[CFG_PAD_H]     = 5'd1;
        geo[CFG_PAD_W]     = 5'd1;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill both stores so that no compute reads an unwritten entry
        for (int a = 0; a < ACT_DEPTH; a++)
            push_cmd(FUNC_LOAD_ACT, ADDR_W'(a), rand_word(), POS_W'($urandom),
                     POS_W'($urandom), $urandom_range(0, 1));
        for (int a = 0; a < WGT_DEPTH; a++)
            push_cmd(FUNC_LOAD_WGT, ADDR_W'(a), rand_word(), POS_W'($urandom),
                     POS_W'($urandom), $urandom_range(0, 1));
        wait_drained();

        // Directed: field extremes, ignored writes, unused code, edge positions
        push_cmd(FUNC_LOAD_ACT, 10'd0, 32'h0000_0000, 5'd0, 5'd0, $urandom_range(0, 3));
        push_cmd(FUNC_LOAD_ACT, 10'd1023, 32'hFFFF_FFFF, 5'd31, 5'd31, $urandom_range(0, 3));
        push_cmd(FUNC_LOAD_WGT, 10'd0, 32'hFFFF_FFFF, 5'd0, 5'd31, $urandom_range(0, 3));
        push_cmd(FUNC_LOAD_WGT, 10'd575, 32'h0000_0000, 5'd31, 5'd0, $urandom_range(0, 3));
        push_cmd(FUNC_LOAD_WGT, 10'd576, $urandom, 5'd0, 5'd0, $urandom_range(0, 3));
        push_cmd(FUNC_LOAD_WGT, 10'd1023, $urandom, 5'd0, 5'd0, $urandom_range(0, 3));
        push_cmd(FUNC_UNUSED, 10'd1023, 32'hFFFF_FFFF, 5'd31, 5'd31, $urandom_range(0, 3));
        push_cmd(FUNC_UNUSED, 10'd0, 32'h0000_0000, 5'd0, 5'd0, 0);
        push_cmd(FUNC_COMPUTE, 10'd1023, 32'hFFFF_FFFF, 5'd0, 5'd0, $urandom_range(0, 3));
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd15, 5'd15, 0);
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd31, 5'd31, $urandom_range(0, 3));
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd16, 5'd0, 0);
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd0, 5'd31, $urandom_range(0, 3));
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd7, 5'd8, 0);
        push_cmd(FUNC_LOAD_ACT, 10'd392, 32'hFFFF_FFFF, 5'd0, 5'd0, 0);
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd7, 5'd8, 0);
        push_cmd(FUNC_COMPUTE, 10'd0, 32'h0000_0000, 5'd15, 5'd15, 0);

        // Smallest legal geometry
        raw = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0};
        run_phase(raw, 25, 3);
        // Largest legal geometry
        raw = '{5'd16, 5'd16, 5'd3, 5'd3, 5'd4, 5'd4, 5'd2, 5'd2};
        run_phase(raw, 25, 0);
        // Zero height, saturated width, zero kernel width, zero stride, raw high bits
        raw = '{5'd0, 5'd31, 5'd31, 5'd4, 5'd0, 5'd31, 5'd31, 5'd2};
        run_phase(raw, 20, 3);
        // Zero width, saturated height, zero column stride
        raw = '{5'd31, 5'd0, 5'd2, 5'd31, 5'd31, 5'd0, 5'd1, 5'd31};
        run_phase(raw, 20, 2);
        // Random geometries
        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < 8; i++)
                raw[i] = rand_geo(cfg_idx_t'(i));
            run_phase(raw, 25, (p == 1) ? 0 : 3);
        end
        // Back to the reset geometry
        raw = '{5'd16, 5'd16, 5'd3, 5'd3, 5'd1, 5'd1, 5'd1, 5'd1};
        run_phase(raw, 35, 3);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d transfers, %0d compute items, %0d channel sums checked",
                 n_xfer, n_compute, n_results);
        $display("tb: %0d register writes over %0d geometry settings", n_cfg, n_settings);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(2_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/xpbc_pkg.sv
design/xpbc_act_mem.sv
design/xpbc_wgt_store.sv
design/xpbc_lane.sv
design/xnor_popcount_binary_conv.sv
dv/tb.sv
